### rtl/bmp_pkg.sv
// Shared types, constants and the modular multiply step for binomial_mod_prime.
// No dependencies; used by every other file of the block.
`default_nettype none

package bmp_pkg;

  // operand width of every residue
  localparam int unsigned OPW = 31;
  // width of the query arguments
  localparam int unsigned NW = 12;
  // modulus after reset
  localparam logic [OPW-1:0] MOD_RESET = 31'd1000000007;
  // cycles from an accepted query to its result strobe
  localparam int unsigned QUERY_LAT = 2 * OPW + 2;

  // query kinds
  localparam logic [1:0] KIND_BINOM   = 2'd0;
  localparam logic [1:0] KIND_CATALAN = 2'd1;
  localparam logic [1:0] KIND_STARS   = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  typedef struct packed {
    logic [1:0]    kind;
    logic [NW-1:0] n_value;
    logic [NW-1:0] r_value;
  } query_t;

  typedef struct packed {
    logic [OPW-1:0] value;
    logic           too_large;
  } result_t;

  // One bit of an MSB-first interleaved multiply: acc' = (2*acc + b_bit*a) mod m.
  // acc and a must already be below m.
  function automatic logic [OPW-1:0] mulmod_step(input logic [OPW-1:0] acc,
                                                 input logic [OPW-1:0] a,
                                                 input logic           b_bit,
                                                 input logic [OPW-1:0] m);
    logic [OPW:0] t;
    t = {acc, 1'b0};
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    if (b_bit) begin
      t = t + {1'b0, a};
    end
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    return t[OPW-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/bmp_mulmod_pipe.sv
// Pipelined modular multiplier, one multiplier bit per register stage.
// Depends on bmp_pkg for the operand width and the step function.
`default_nettype none

module bmp_mulmod_pipe #(
  parameter int unsigned SW = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [bmp_pkg::OPW-1:0]  a_i,
  input  logic [bmp_pkg::OPW-1:0]  b_i,
  input  logic [SW-1:0]            side_i,
  input  logic [bmp_pkg::OPW-1:0]  mod_i,
  output logic                     valid_o,
  output logic [bmp_pkg::OPW-1:0]  prod_o,
  output logic [SW-1:0]            side_o
);

  localparam int unsigned OPW = bmp_pkg::OPW;

  logic           vld_q  [OPW];
  logic [OPW-1:0] acc_q  [OPW];
  logic [OPW-1:0] a_q    [OPW];
  logic [OPW-1:0] b_q    [OPW];
  logic [SW-1:0]  side_q [OPW];

  logic           in_vld  [OPW];
  logic [OPW-1:0] in_acc  [OPW];
  logic [OPW-1:0] in_a    [OPW];
  logic [OPW-1:0] in_b    [OPW];
  logic [SW-1:0]  in_side [OPW];
  logic [OPW-1:0] acc_d   [OPW];

  // feed each stage from the one before; stage k consumes bit OPW-1-k of b
  always_comb begin
    for (int k = 0; k < OPW; k++) begin
      if (k == 0) begin
        in_vld[k]  = valid_i;
        in_acc[k]  = '0;
        in_a[k]    = a_i;
        in_b[k]    = b_i;
        in_side[k] = side_i;
      end else begin
        in_vld[k]  = vld_q[k-1];
        in_acc[k]  = acc_q[k-1];
        in_a[k]    = a_q[k-1];
        in_b[k]    = b_q[k-1];
        in_side[k] = side_q[k-1];
      end
      acc_d[k] = bmp_pkg::mulmod_step(in_acc[k], in_a[k], in_b[k][OPW-1-k], mod_i);
    end
  end

  // advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < OPW; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      for (int k = 0; k < OPW; k++) begin
        vld_q[k] <= in_vld[k];
      end
    end
  end

  // advance payload
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < OPW; k++) begin
      acc_q[k]  <= acc_d[k];
      a_q[k]    <= in_a[k];
      b_q[k]    <= in_b[k];
      side_q[k] <= in_side[k];
    end
  end

  assign valid_o = vld_q[OPW-1];
  assign prod_o  = acc_q[OPW-1];
  assign side_o  = side_q[OPW-1];

endmodule

`default_nettype wire

### rtl/binomial_mod_prime.sv
// Top level of binomial_mod_prime: table builder, factorial stores, query pipeline.
// Depends on bmp_pkg and bmp_mulmod_pipe.
//
// Usage:
//   Query word on query_i (kind, n_value, r_value) is taken at a rising edge with
//   start_i high and busy_o low. Kinds: binomial C(n,r), Catalan of n, stars and
//   bars C(n+r-1,r-1). The result word appears on result_o for exactly one cycle
//   with result_valid_o high; the receiver cannot hold it off. One query may be
//   taken every cycle while busy_o is low. A query passes the registered table read,
//   two chained 31-stage modular multipliers and the output register.
//   The modulus is written on cfg_data_i with cfg_valid_i (cfg_ready_o is always
//   high). After reset and after every write the factorial and inverse-factorial
//   tables are rebuilt by one bit-serial multiplier, one product at a time, while
//   busy_o stays high. A modulus below 2 skips the build and every value reads 0.
//   An index above MAX_N sets too_large with value 0.
`default_nettype none

module binomial_mod_prime #(
  parameter int unsigned MAX_N = 4095
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  bmp_pkg::query_t          query_i,
  output logic                     result_valid_o,
  output bmp_pkg::result_t         result_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [bmp_pkg::OPW-1:0]  cfg_data_i
);

  localparam int unsigned OPW   = bmp_pkg::OPW;
  localparam int unsigned DEPTH = MAX_N + 1;
  localparam int unsigned IW    = $clog2(DEPTH);
  localparam logic [IW-1:0] IDX_TOP = IW'(MAX_N);

  typedef enum logic [4:0] {
    ST_FACT    = 5'b00001,
    ST_POW_SQ  = 5'b00010,
    ST_POW_MUL = 5'b00100,
    ST_INV     = 5'b01000,
    ST_READY   = 5'b10000
  } build_state_e;

  build_state_e   state_q;
  logic [OPW-1:0] modulus_q;
  logic [IW-1:0]  idx_q;
  logic [IW-1:0]  imod_q;
  logic [OPW-1:0] prev_q;
  logic [OPW-1:0] base_q;
  logic [4:0]     ebit_q;
  logic           mul_run_q;
  logic [4:0]     mul_cnt_q;
  logic [OPW-1:0] mul_acc_q;

  logic [OPW-1:0] op_a;
  logic [OPW-1:0] op_b;
  logic [OPW-1:0] mul_res;
  logic           mul_done;
  logic           mul_kick;
  logic [OPW-1:0] expo;
  logic           cfg_wr;
  logic [IW-1:0]  imod_up;
  logic [IW-1:0]  imod_dn;

  logic [OPW-1:0] fact_mem [DEPTH];
  logic [OPW-1:0] inva_mem [DEPTH];
  logic [OPW-1:0] invb_mem [DEPTH];

  logic           fact_we;
  logic [IW-1:0]  fact_waddr;
  logic [OPW-1:0] fact_wdata;
  logic           inv_we;
  logic [IW-1:0]  inv_waddr;
  logic [OPW-1:0] inv_wdata;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;
  assign busy_o      = (state_q != ST_READY);
  assign expo        = modulus_q - 31'd2;

  // running index modulo the modulus, stepped up and down
  assign imod_up = ((32'(imod_q) + 32'd1) == 32'(modulus_q)) ? '0 : imod_q + 1'b1;
  assign imod_dn = (imod_q == '0) ? IW'(modulus_q - 31'd1) : imod_q - 1'b1;

  // select multiplier operands for the build step in hand
  always_comb begin
    op_a = prev_q;
    op_b = 31'(imod_q);
    case (state_q)
      ST_POW_SQ:  op_b = prev_q;
      ST_POW_MUL: op_b = base_q;
      default:    op_b = 31'(imod_q);
    endcase
  end

  assign mul_res  = bmp_pkg::mulmod_step(mul_acc_q, op_a, op_b[mul_cnt_q], modulus_q);
  assign mul_done = mul_run_q && (mul_cnt_q == 5'd0);
  assign mul_kick = (state_q != ST_READY) && !mul_run_q;

  // sequence the table build
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= bmp_pkg::MOD_RESET;
      state_q   <= ST_FACT;
      idx_q     <= IW'(1);
      imod_q    <= IW'(1);
      prev_q    <= 31'd1;
      base_q    <= '0;
      ebit_q    <= '0;
      mul_run_q <= 1'b0;
      mul_cnt_q <= '0;
      mul_acc_q <= '0;
    end else if (cfg_wr) begin
      modulus_q <= cfg_data_i;
      state_q   <= (cfg_data_i < 31'd2) ? ST_READY : ST_FACT;
      idx_q     <= IW'(1);
      imod_q    <= IW'(1);
      prev_q    <= 31'd1;
      mul_run_q <= 1'b0;
    end else if (mul_kick) begin
      mul_run_q <= 1'b1;
      mul_acc_q <= '0;
      mul_cnt_q <= 5'(OPW - 1);
    end else if (mul_run_q) begin
      mul_acc_q <= mul_res;
      mul_cnt_q <= mul_cnt_q - 5'd1;
      if (mul_done) begin
        mul_run_q <= 1'b0;
        prev_q    <= mul_res;
        unique case (state_q)
          ST_FACT: begin
            if (idx_q == IDX_TOP) begin
              state_q <= ST_POW_SQ;
              base_q  <= mul_res;
              prev_q  <= 31'd1;
              ebit_q  <= 5'(OPW - 1);
            end else begin
              idx_q  <= idx_q + 1'b1;
              imod_q <= imod_up;
            end
          end
          ST_POW_SQ: begin
            if (expo[ebit_q]) begin
              state_q <= ST_POW_MUL;
            end else if (ebit_q == 5'd0) begin
              state_q <= ST_INV;
            end else begin
              ebit_q <= ebit_q - 5'd1;
            end
          end
          ST_POW_MUL: begin
            if (ebit_q == 5'd0) begin
              state_q <= ST_INV;
            end else begin
              ebit_q  <= ebit_q - 5'd1;
              state_q <= ST_POW_SQ;
            end
          end
          ST_INV: begin
            if (idx_q == IW'(1)) begin
              state_q <= ST_READY;
            end else begin
              idx_q  <= idx_q - 1'b1;
              imod_q <= imod_dn;
            end
          end
          default: state_q <= ST_READY;
        endcase
      end
    end
  end

  // table write ports
  always_comb begin
    fact_we    = 1'b0;
    fact_waddr = idx_q;
    fact_wdata = mul_res;
    inv_we     = 1'b0;
    inv_waddr  = idx_q - 1'b1;
    inv_wdata  = mul_res;
    if (!cfg_wr && state_q == ST_FACT) begin
      if (mul_kick && idx_q == IW'(1)) begin
        fact_we    = 1'b1;
        fact_waddr = '0;
        fact_wdata = 31'd1;
      end else if (mul_done) begin
        fact_we = 1'b1;
      end
    end
    if (!cfg_wr && state_q == ST_INV) begin
      if (mul_kick && idx_q == IDX_TOP) begin
        inv_we    = 1'b1;
        inv_waddr = IDX_TOP;
        inv_wdata = prev_q;
      end else if (mul_done) begin
        inv_we = 1'b1;
      end
    end
  end

  // query decode: table addresses and flags
  logic [31:0]    n32, r32, top32, fa32, a1_32, a2_32, b1_32, b2_32;
  logic           need, flag, zero, cat, buse;
  logic           q_acc;

  assign n32   = 32'(query_i.n_value);
  assign r32   = 32'(query_i.r_value);
  assign q_acc = start_i & ~busy_o;

  always_comb begin
    need  = 1'b0;
    cat   = 1'b0;
    buse  = 1'b0;
    top32 = n32;
    fa32  = n32;
    a1_32 = r32;
    a2_32 = n32 - r32;
    b1_32 = '0;
    b2_32 = '0;
    case (query_i.kind)
      bmp_pkg::KIND_BINOM: begin
        need = (r32 <= n32);
      end
      bmp_pkg::KIND_CATALAN: begin
        need  = 1'b1;
        cat   = 1'b1;
        buse  = (n32 != 32'd0);
        top32 = n32 + n32;
        fa32  = n32 + n32;
        a1_32 = n32;
        a2_32 = n32;
        b1_32 = n32 + 32'd1;
        b2_32 = n32 - 32'd1;
      end
      bmp_pkg::KIND_STARS: begin
        need  = (r32 != 32'd0);
        top32 = n32 + r32 - 32'd1;
        fa32  = n32 + r32 - 32'd1;
        a1_32 = r32 - 32'd1;
        a2_32 = n32;
      end
      default: need = 1'b0;
    endcase
    flag = need && (top32 > 32'(MAX_N));
    zero = !need || flag || (modulus_q < 31'd2);
  end

  logic [IW-1:0] fa_ad, a1_ad, a2_ad, b1_ad, b2_ad;
  assign fa_ad = zero ? '0 : fa32[IW-1:0];
  assign a1_ad = zero ? '0 : a1_32[IW-1:0];
  assign a2_ad = zero ? '0 : a2_32[IW-1:0];
  assign b1_ad = (zero || !buse) ? '0 : b1_32[IW-1:0];
  assign b2_ad = (zero || !buse) ? '0 : b2_32[IW-1:0];

  // table memories: write from the builder, registered reads for queries
  logic [OPW-1:0] f_q, x1_q, y1_q, x2_q, y2_q;
  logic           cat_q, zero_q, flag_q, buse_q;
  logic           rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (fact_we) begin
      fact_mem[fact_waddr] <= fact_wdata;
    end
    if (inv_we) begin
      inva_mem[inv_waddr] <= inv_wdata;
      invb_mem[inv_waddr] <= inv_wdata;
    end
    f_q    <= fact_mem[fa_ad];
    x1_q   <= inva_mem[a1_ad];
    y1_q   <= inva_mem[a2_ad];
    x2_q   <= invb_mem[b1_ad];
    y2_q   <= invb_mem[b2_ad];
    cat_q  <= cat;
    zero_q <= zero;
    flag_q <= flag;
    buse_q <= buse;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= q_acc;
    end
  end

  // two lanes, each f * x * y mod m through two chained multipliers
  logic           va1, vb1, va2, vb2;
  logic [OPW-1:0] pa1, pb1, pa2, pb2;
  logic [OPW+2:0] sa1;
  logic [OPW:0]   sb1;
  logic [2:0]     sa2;
  logic           sb2;

  bmp_mulmod_pipe #(.SW(OPW + 3)) u_mul_a1 (
    .clk_i, .rst_ni,
    .valid_i (rd_vld_q),
    .a_i     (f_q),
    .b_i     (x1_q),
    .side_i  ({y1_q, cat_q, zero_q, flag_q}),
    .mod_i   (modulus_q),
    .valid_o (va1),
    .prod_o  (pa1),
    .side_o  (sa1)
  );

  bmp_mulmod_pipe #(.SW(OPW + 1)) u_mul_b1 (
    .clk_i, .rst_ni,
    .valid_i (rd_vld_q),
    .a_i     (f_q),
    .b_i     (x2_q),
    .side_i  ({y2_q, buse_q}),
    .mod_i   (modulus_q),
    .valid_o (vb1),
    .prod_o  (pb1),
    .side_o  (sb1)
  );

  bmp_mulmod_pipe #(.SW(3)) u_mul_a2 (
    .clk_i, .rst_ni,
    .valid_i (va1),
    .a_i     (pa1),
    .b_i     (sa1[OPW+2:3]),
    .side_i  (sa1[2:0]),
    .mod_i   (modulus_q),
    .valid_o (va2),
    .prod_o  (pa2),
    .side_o  (sa2)
  );

  bmp_mulmod_pipe #(.SW(1)) u_mul_b2 (
    .clk_i, .rst_ni,
    .valid_i (vb1),
    .a_i     (pb1),
    .b_i     (sb1[OPW:1]),
    .side_i  (sb1[0]),
    .mod_i   (modulus_q),
    .valid_o (vb2),
    .prod_o  (pb2),
    .side_o  (sb2)
  );

  // combine lanes: Catalan takes the difference modulo m
  logic [31:0]      diff;
  logic [OPW-1:0]   cat_val;
  bmp_pkg::result_t res_d, res_q;
  logic             res_vld_q;

  always_comb begin
    diff = 32'(pa2) - 32'(pb2);
    if (diff[31]) begin
      diff = diff + 32'(modulus_q);
    end
    cat_val = (sa2[2] && sb2) ? diff[OPW-1:0] : pa2;
    res_d.value     = sa2[1] ? '0 : cat_val;
    res_d.too_large = sa2[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= va2 & vb2;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

endmodule

`default_nettype wire

### rtl/bmp_checker.sv
// Port-level checks for binomial_mod_prime and the bind that attaches them.
// Depends on bmp_pkg and the top level's port list.
`default_nettype none

module bmp_checker #(
  parameter int unsigned LAT = bmp_pkg::QUERY_LAT
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start_i,
  input logic                     busy_o,
  input logic                     result_valid_o,
  input bmp_pkg::result_t         result_o,
  input logic                     cfg_valid_i,
  input logic                     cfg_ready_o,
  input logic [bmp_pkg::OPW-1:0]  cfg_data_i
);

  // a flagged word carries value zero
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.too_large |-> result_o.value == '0)
    else $error("too_large word with nonzero value");

  // every result word traces back to a query taken a fixed time earlier
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o, LAT))
    else $error("result word without a matching query");

  // a usable modulus write starts a rebuild
  a_rebuild: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o && (cfg_data_i >= 31'd2) |=> busy_o)
    else $error("modulus write did not start a rebuild");

  // the block builds its tables straight out of reset
  a_reset_busy: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> busy_o)
    else $error("not busy after reset");

endmodule

bind binomial_mod_prime bmp_checker u_bmp_checker (.*);

`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for binomial_mod_prime: queries and modulus writes.
// It predicts each result from its own factorial tables and checks them in order.
// Depends on bmp_pkg and the binomial_mod_prime RTL.
`timescale 1ns / 100ps

// Holds the predicted factorial tables and the queue of expected result words
class combo_scoreboard;
  localparam int unsigned TOP = 4095;
  longint unsigned modulus;
  longint unsigned fact_tab[TOP+1];
  longint unsigned inv_fact_tab[TOP+1];
  bmp_pkg::result_t expected_results[$];
  int unsigned mismatches;

  function longint unsigned pow_mod(longint unsigned base, longint unsigned ex,
                                    longint unsigned m);
    longint unsigned acc;
    acc = 1 % m;
    base = base % m;
    while (ex > 0) begin
      if (ex[0]) acc = acc * base % m;
      base = base * base % m;
      ex = ex >> 1;
    end
    return acc;
  endfunction

  // Rebuild both tables for a new modulus
  function void set_modulus(logic [bmp_pkg::OPW-1:0] m_word);
    longint unsigned m;
    modulus = m_word;
    m = modulus;
    if (m < 2) begin
      foreach (fact_tab[i]) begin
        fact_tab[i] = 0;
        inv_fact_tab[i] = 0;
      end
      return;
    end
    fact_tab[0] = 1;
    for (int i = 1; i <= TOP; i++) fact_tab[i] = fact_tab[i-1] * (i % m) % m;
    inv_fact_tab[TOP] = pow_mod(fact_tab[TOP], m - 2, m);
    for (int i = TOP; i > 0; i--) inv_fact_tab[i-1] = inv_fact_tab[i] * (i % m) % m;
  endfunction

  function longint unsigned choose(int unsigned n, int unsigned r);
    longint unsigned v;
    v = fact_tab[n] * inv_fact_tab[r] % modulus;
    return v * inv_fact_tab[n-r] % modulus;
  endfunction

  // Work out the result of one query
  function bmp_pkg::result_t predict_query(bmp_pkg::query_t q);
    bmp_pkg::result_t res;
    int unsigned n, r, top;
    longint unsigned a, b, v;
    n = q.n_value;
    r = q.r_value;
    v = 0;
    res.too_large = 1'b0;
    case (q.kind)
      bmp_pkg::KIND_BINOM: begin
        if (r <= n) begin
          if (n > TOP) res.too_large = 1'b1;
          else if (modulus >= 2) v = choose(n, r);
        end
      end
      bmp_pkg::KIND_CATALAN: begin
        top = 2 * n;
        if (top > TOP) res.too_large = 1'b1;
        else if (modulus >= 2) begin
          a = choose(top, n);
          b = (n + 1 <= top) ? choose(top, n + 1) : 0;
          v = (a + modulus - b) % modulus;
        end
      end
      bmp_pkg::KIND_STARS: begin
        if (r >= 1) begin
          top = n + r - 1;
          if (top > TOP) res.too_large = 1'b1;
          else if (modulus >= 2) v = choose(top, r - 1);
        end
      end
      default: v = 0;
    endcase
    res.value = v[bmp_pkg::OPW-1:0];
    return res;
  endfunction

  function void note_query(bmp_pkg::query_t q);
    expected_results.push_back(predict_query(q));
  endfunction

  // Compare one result word with the oldest expectation
  function void check_result(bmp_pkg::result_t got);
    bmp_pkg::result_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result word: value %0d too_large %0d", got.value, got.too_large);
      return;
    end
    want = expected_results.pop_front();
    if (got.value !== want.value || got.too_large !== want.too_large) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected value %0d too_large %0d, got value %0d too_large %0d",
                 want.value, want.too_large, got.value, got.too_large);
    end
  endfunction
endclass

module testbench;

  localparam int unsigned TABLE_TOP = 4095;
  localparam int unsigned STALL_LIMIT = 1200000;
  localparam int unsigned RANDOM_PER_PHASE = 270;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  bmp_pkg::query_t query_i = '0;
  logic result_valid_o;
  bmp_pkg::result_t result_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [bmp_pkg::OPW-1:0] cfg_data_i = '0;

  combo_scoreboard sb;
  int unsigned quiet_cycles = 0;

  binomial_mod_prime #(.MAX_N(TABLE_TOP)) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .query_i        (query_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Note accepted queries and check result words at each edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) sb.note_query(query_i);
      if (result_valid_o) sb.check_result(result_o);
    end
  end

  // Abort when nothing has moved for too long
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Hold one query word until the block takes it
  task automatic send_query(logic [1:0] kind, int unsigned n, int unsigned r);
    bmp_pkg::query_t q;
    q.kind = kind;
    q.n_value = n[bmp_pkg::NW-1:0];
    q.r_value = r[bmp_pkg::NW-1:0];
    start_i <= 1'b1;
    query_i <= q;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic idle_cycles(int unsigned count);
    start_i <= 1'b0;
    repeat (count) @(posedge clk_i);
  endtask

  // Let every result drain, then write the modulus and wait out the rebuild start
  task automatic write_modulus(logic [bmp_pkg::OPW-1:0] m);
    start_i <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (bmp_pkg::QUERY_LAT + 4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_modulus(m);
    cfg_valid_i <= 1'b0;
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_directed();
    send_query(bmp_pkg::KIND_BINOM, 0, 0);
    send_query(bmp_pkg::KIND_BINOM, 4095, 0);
    send_query(bmp_pkg::KIND_BINOM, 4095, 4095);
    send_query(bmp_pkg::KIND_BINOM, 4095, 2047);
    send_query(bmp_pkg::KIND_BINOM, 5, 6);
    send_query(bmp_pkg::KIND_BINOM, 0, 4095);
    send_query(bmp_pkg::KIND_CATALAN, 0, 4095);
    send_query(bmp_pkg::KIND_CATALAN, 1, 0);
    send_query(bmp_pkg::KIND_CATALAN, 2047, 0);
    send_query(bmp_pkg::KIND_CATALAN, 2048, 0);
    send_query(bmp_pkg::KIND_CATALAN, 4095, 4095);
    send_query(bmp_pkg::KIND_STARS, 0, 0);
    send_query(bmp_pkg::KIND_STARS, 4095, 0);
    send_query(bmp_pkg::KIND_STARS, 0, 1);
    send_query(bmp_pkg::KIND_STARS, 4095, 1);
    send_query(bmp_pkg::KIND_STARS, 4095, 2);
    send_query(bmp_pkg::KIND_STARS, 1, 4095);
    send_query(bmp_pkg::KIND_STARS, 2, 4095);
    send_query(bmp_pkg::KIND_NONE, 4095, 4095);
    send_query(bmp_pkg::KIND_NONE, 0, 0);
  endtask

  // Mostly in-range queries with random content, some raw field noise
  task automatic run_random(int unsigned count);
    int unsigned n, r, pick;
    logic [1:0] kind;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      kind = (pick < 3) ? bmp_pkg::KIND_NONE : 2'($urandom_range(0, 2));
      n = $urandom_range(0, 4095);
      r = $urandom_range(0, 4095);
      if ($urandom_range(0, 3) != 0) begin
        case (kind)
          bmp_pkg::KIND_BINOM: r = $urandom_range(0, (n + 8 > 4095) ? 4095 : n + 8);
          bmp_pkg::KIND_CATALAN: n = $urandom_range(0, 2047);
          bmp_pkg::KIND_STARS: r = $urandom_range(1, 4096 - n);
          default: n = n;
        endcase
      end
      // keep a long stretch free of gaps
      if ((i < 80 || i > 180) && $urandom_range(0, 99) < 14)
        idle_cycles($urandom_range(1, 4));
      send_query(kind, n, r);
    end
  endtask

  initial begin
    logic [bmp_pkg::OPW-1:0] moduli [3];
    moduli[0] = 31'd2147483647;
    moduli[1] = 31'd4099;
    moduli[2] = 31'd2;
    sb = new();
    sb.set_modulus(bmp_pkg::MOD_RESET);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_random(RANDOM_PER_PHASE);
    foreach (moduli[k]) begin
      write_modulus(moduli[k]);
      run_directed();
      run_random(RANDOM_PER_PHASE);
    end
    start_i <= 1'b0;

    // Drain outstanding results, then allow for late strays
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (bmp_pkg::QUERY_LAT + 16) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
